FILE: hw/rtl/hsvws_pkg.sv
// Shared types, constants and helpers for the HSV window similarity average block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package hsvws_pkg;

  localparam int K         = 5;
  localparam int RAD       = (K - 1) / 2;
  localparam int MAX_WIDTH = 1024;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int SLOT_W    = $clog2(K);
  localparam int MEM_DEPTH = K * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int ROW_W     = 12;
  localparam int POS_W     = 13;
  localparam int WIN_N     = K * K;
  localparam int IDX_W     = $clog2(WIN_N);
  localparam int GOOD_W    = $clog2(WIN_N + 2);
  localparam int SUM_W     = $clog2(255 * (WIN_N + 1) + 1);
  localparam int DCNT_W    = $clog2(SUM_W);
  localparam int REM_W     = GOOD_W + 1;
  localparam int PIX_W     = 24;

  localparam logic [8:0] HUE_SPAN = 9'd180;
  localparam logic [7:0] HUE_HALF = 8'd90;
  localparam logic [7:0] HUE_TOP  = 8'd179;

  typedef enum logic [2:0] {
    REG_HUE_WINDOW   = 3'd0,
    REG_SAT_WINDOW   = 3'd1,
    REG_VAL_WINDOW   = 3'd2,
    REG_SAT_FLOOR    = 3'd3,
    REG_VAL_FLOOR    = 3'd4,
    REG_GOOD_FACTOR  = 3'd5,
    REG_LINE_WIDTH   = 3'd6,
    REG_FRAME_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [6:0]  hue_window;
    logic [7:0]  sat_window;
    logic [7:0]  val_window;
    logic [7:0]  sat_floor;
    logic [7:0]  val_floor;
    logic [6:0]  good_factor;
    logic [10:0] line_width;
    logic [11:0] frame_height;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CENTER,
    ST_SCAN,
    ST_DRAIN,
    ST_DIVLD,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic rd_center;
    logic rd_nbr;
    logic div_load;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic interior;
    logic scan_last;
    logic div_done;
  } sts_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(K - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

endpackage

FILE: hw/rtl/hsvws_ctrl.sv
// Controller state machine for the HSV window similarity average block.
// Depends on hsvws_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module hsvws_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  hsvws_pkg::sts_t sts,
  output hsvws_pkg::cmd_t cmd
);

  hsvws_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsvws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hsvws_pkg::ST_IDLE:   if (in_tvalid) state_nxt = hsvws_pkg::ST_WRITE;
      hsvws_pkg::ST_WRITE:  state_nxt = sts.interior ? hsvws_pkg::ST_CENTER
                                                     : hsvws_pkg::ST_IDLE;
      hsvws_pkg::ST_CENTER: state_nxt = hsvws_pkg::ST_SCAN;
      hsvws_pkg::ST_SCAN:   if (sts.scan_last) state_nxt = hsvws_pkg::ST_DRAIN;
      hsvws_pkg::ST_DRAIN:  state_nxt = hsvws_pkg::ST_DIVLD;
      hsvws_pkg::ST_DIVLD:  state_nxt = hsvws_pkg::ST_DIV;
      hsvws_pkg::ST_DIV:    if (sts.div_done) state_nxt = hsvws_pkg::ST_FIN;
      hsvws_pkg::ST_FIN:    state_nxt = hsvws_pkg::ST_OUT;
      hsvws_pkg::ST_OUT:    if (out_tready) state_nxt = hsvws_pkg::ST_IDLE;
      default:              state_nxt = hsvws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      hsvws_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      hsvws_pkg::ST_WRITE:  cmd.write     = 1'b1;
      hsvws_pkg::ST_CENTER: cmd.rd_center = 1'b1;
      hsvws_pkg::ST_SCAN:   cmd.rd_nbr    = 1'b1;
      hsvws_pkg::ST_DRAIN:  cmd           = '0;
      hsvws_pkg::ST_DIVLD:  cmd.div_load  = 1'b1;
      hsvws_pkg::ST_DIV:    cmd.div_step  = 1'b1;
      hsvws_pkg::ST_FIN:    cmd.load_out  = 1'b1;
      hsvws_pkg::ST_OUT:    out_tvalid    = 1'b1;
      default:              cmd           = '0;
    endcase
  end

endmodule

FILE: hw/rtl/hsvws_datapath.sv
// Datapath of the HSV window similarity average block: position counters,
// line store, window scan and accumulation, shared divider, result register.
// Depends on hsvws_pkg; commanded by hsvws_ctrl.
`timescale 1ns / 1ps

module hsvws_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hsvws_pkg::cfg_t                cfg,
  input  logic [hsvws_pkg::PIX_W-1:0]    pix_in,
  input  hsvws_pkg::cmd_t                cmd,
  output hsvws_pkg::sts_t                sts,
  output logic [hsvws_pkg::PIX_W-1:0]    res_data,
  output logic                           res_avg,
  output logic                           res_last
);

  localparam int PW = hsvws_pkg::POS_W;
  localparam int SW = hsvws_pkg::SLOT_W;
  localparam int CW = hsvws_pkg::COL_W;

  // Position of the next pixel.
  logic [CW-1:0]                  col_r;
  logic [hsvws_pkg::ROW_W-1:0]    row_r;
  logic [SW-1:0]                  slot_r;
  // The item in flight.
  logic [CW-1:0]                  pcol_r;
  logic [SW-1:0]                  pslot_r;
  logic [hsvws_pkg::PIX_W-1:0]    pix_r;
  logic                           interior_r, last_r;

  logic [PW-1:0] w_eff, h_eff, lw, c0, r0, r1, cp1;
  logic [SW-1:0] s0, s1;
  logic [CW-1:0] c1;

  always_comb begin
    lw = PW'(cfg.line_width);
    if (lw < PW'(hsvws_pkg::K)) begin
      w_eff = PW'(hsvws_pkg::K);
    end else if (lw > PW'(hsvws_pkg::MAX_WIDTH)) begin
      w_eff = PW'(hsvws_pkg::MAX_WIDTH);
    end else begin
      w_eff = lw;
    end
    h_eff = (PW'(cfg.frame_height) < PW'(hsvws_pkg::K)) ? PW'(hsvws_pkg::K)
                                                         : PW'(cfg.frame_height);
    c0 = PW'(col_r);
    r0 = PW'(row_r);
    s0 = slot_r;
    if (c0 >= w_eff) begin
      c0 = '0;
      r0 = r0 + PW'(1);
      s0 = hsvws_pkg::slot_inc(s0);
    end
    if (r0 >= h_eff) begin
      r0 = '0;
      s0 = '0;
    end
    cp1 = c0 + PW'(1);
    if (cp1 >= w_eff) begin
      c1 = '0;
      r1 = r0 + PW'(1);
      s1 = hsvws_pkg::slot_inc(s0);
      if (r1 >= h_eff) begin
        r1 = '0;
        s1 = '0;
      end
    end else begin
      c1 = CW'(cp1);
      r1 = r0;
      s1 = s0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (cmd.capture) begin
      col_r  <= c1;
      row_r  <= hsvws_pkg::ROW_W'(r1);
      slot_r <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r      <= pix_in;
      pcol_r     <= CW'(c0);
      pslot_r    <= s0;
      interior_r <= (r0 >= PW'(hsvws_pkg::K - 1)) && (c0 >= PW'(hsvws_pkg::K - 1));
      last_r     <= (r0 == h_eff - PW'(1)) && (c0 == w_eff - PW'(1));
    end
  end

  // Line store: one row of MAX_WIDTH pixels per slot, registered read.
  logic [hsvws_pkg::PIX_W-1:0]  mem [hsvws_pkg::MEM_DEPTH];
  logic [hsvws_pkg::PIX_W-1:0]  rdata_r;
  logic [hsvws_pkg::ADDR_W-1:0] raddr;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[{pslot_r, pcol_r}] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  // Window walk: oldest row first, left to right.
  logic [SW-1:0]                 ns_r;
  logic [CW-1:0]                 nc_r;
  logic [SW-1:0]                 dc_r;
  logic [hsvws_pkg::IDX_W-1:0]   idx_r;
  logic [SW:0]                   cs_sum;
  logic [SW-1:0]                 cslot;
  logic [CW-1:0]                 ccol, col_start;

  always_comb begin
    cs_sum    = (SW+1)'(pslot_r) + (SW+1)'(hsvws_pkg::K - hsvws_pkg::RAD);
    cslot     = (cs_sum >= (SW+1)'(hsvws_pkg::K)) ? SW'(cs_sum - (SW+1)'(hsvws_pkg::K))
                                                  : SW'(cs_sum);
    ccol      = pcol_r - CW'(hsvws_pkg::RAD);
    col_start = pcol_r - CW'(hsvws_pkg::K - 1);
    raddr     = cmd.rd_center ? {cslot, ccol} : {ns_r, nc_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_center) begin
      ns_r  <= hsvws_pkg::slot_inc(pslot_r);
      nc_r  <= col_start;
      dc_r  <= '0;
      idx_r <= '0;
    end else if (cmd.rd_nbr) begin
      idx_r <= idx_r + hsvws_pkg::IDX_W'(1);
      if (dc_r == SW'(hsvws_pkg::K - 1)) begin
        dc_r <= '0;
        nc_r <= col_start;
        ns_r <= hsvws_pkg::slot_inc(ns_r);
      end else begin
        dc_r <= dc_r + SW'(1);
        nc_r <= nc_r + CW'(1);
      end
    end
  end

  // Which kind of read is landing in rdata_r this cycle.
  logic rd_c_q, rd_n_q;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_c_q <= 1'b0;
      rd_n_q <= 1'b0;
    end else begin
      rd_c_q <= cmd.rd_center;
      rd_n_q <= cmd.rd_nbr;
    end
  end

  // Similarity test of a neighbor against the latched centre.
  logic [7:0] hc_r, sc_r, vc_r;
  logic [7:0] hn, sn, vn, dh, ds, dv, addh;
  logic [9:0] tsig, dsig, hwsig;
  logic       hue_ok, similar, dgt, near_lo, near_hi;

  always_comb begin
    hn    = rdata_r[7:0];
    sn    = rdata_r[15:8];
    vn    = rdata_r[23:16];
    dh    = (hc_r > hn) ? hc_r - hn : hn - hc_r;
    ds    = (sc_r > sn) ? sc_r - sn : sn - sc_r;
    dv    = (vc_r > vn) ? vc_r - vn : vn - vc_r;
    dsig  = {2'b00, dh};
    hwsig = {3'b000, cfg.hue_window};
    tsig  = 10'(hsvws_pkg::HUE_SPAN) - dsig;
    hue_ok = ($signed(tsig) < $signed(dsig)) ? ($signed(tsig) <= $signed(hwsig))
                                             : (dsig <= hwsig);
    similar = hue_ok && (ds <= cfg.sat_window) && (dv <= cfg.val_window);
    dgt     = dh > hsvws_pkg::HUE_HALF;
    near_lo = hc_r <= {1'b0, cfg.hue_window};
    near_hi = ({1'b0, hc_r} + {2'b00, cfg.hue_window}) >= hsvws_pkg::HUE_SPAN;
    if (near_lo && dgt) begin
      addh = '0;
    end else if (near_hi && dgt) begin
      addh = hsvws_pkg::HUE_TOP;
    end else begin
      addh = hn;
    end
  end

  logic [hsvws_pkg::SUM_W-1:0]  hs_r, ss_r, vs_r;
  logic [hsvws_pkg::GOOD_W-1:0] good_r;
  logic                         filt_r;

  always_ff @(posedge clk) begin
    if (rd_c_q) begin
      hc_r   <= rdata_r[7:0];
      sc_r   <= rdata_r[15:8];
      vc_r   <= rdata_r[23:16];
      hs_r   <= hsvws_pkg::SUM_W'(rdata_r[7:0]);
      ss_r   <= hsvws_pkg::SUM_W'(rdata_r[15:8]);
      vs_r   <= hsvws_pkg::SUM_W'(rdata_r[23:16]);
      good_r <= hsvws_pkg::GOOD_W'(1);
      filt_r <= (rdata_r[15:8] >= cfg.sat_floor) && (rdata_r[23:16] >= cfg.val_floor);
    end else if (rd_n_q && similar) begin
      hs_r   <= hs_r + hsvws_pkg::SUM_W'(addh);
      ss_r   <= ss_r + hsvws_pkg::SUM_W'(sn);
      vs_r   <= vs_r + hsvws_pkg::SUM_W'(vn);
      good_r <= good_r + hsvws_pkg::GOOD_W'(1);
    end
  end

  // Restoring divider, three lanes sharing the divisor, one quotient bit a cycle.
  logic [hsvws_pkg::SUM_W-1:0]  qh_r, qs_r, qv_r;
  logic [hsvws_pkg::REM_W-1:0]  rh_r, rs_r, rv_r;
  logic [hsvws_pkg::DCNT_W-1:0] dcnt_r;
  logic [hsvws_pkg::REM_W-1:0]  th, ts, tv, dvs;

  always_comb begin
    dvs = hsvws_pkg::REM_W'(good_r);
    th  = {rh_r[hsvws_pkg::REM_W-2:0], qh_r[hsvws_pkg::SUM_W-1]};
    ts  = {rs_r[hsvws_pkg::REM_W-2:0], qs_r[hsvws_pkg::SUM_W-1]};
    tv  = {rv_r[hsvws_pkg::REM_W-2:0], qv_r[hsvws_pkg::SUM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      qh_r   <= hs_r;
      qs_r   <= ss_r;
      qv_r   <= vs_r;
      rh_r   <= '0;
      rs_r   <= '0;
      rv_r   <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + hsvws_pkg::DCNT_W'(1);
      rh_r   <= (th >= dvs) ? th - dvs : th;
      rs_r   <= (ts >= dvs) ? ts - dvs : ts;
      rv_r   <= (tv >= dvs) ? tv - dvs : tv;
      qh_r   <= {qh_r[hsvws_pkg::SUM_W-2:0], th >= dvs};
      qs_r   <= {qs_r[hsvws_pkg::SUM_W-2:0], ts >= dvs};
      qv_r   <= {qv_r[hsvws_pkg::SUM_W-2:0], tv >= dvs};
    end
  end

  // Ratio test and result register.
  logic [6+hsvws_pkg::GOOD_W:0] ratio;
  logic                         pass;
  always_comb begin
    ratio = (7+hsvws_pkg::GOOD_W)'(cfg.good_factor) * (7+hsvws_pkg::GOOD_W)'(good_r);
    pass  = filt_r && (ratio >= (7+hsvws_pkg::GOOD_W)'(hsvws_pkg::WIN_N + 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_data <= pass ? {qv_r[7:0], qs_r[7:0], qh_r[7:0]} : '0;
      res_avg  <= pass;
      res_last <= last_r;
    end
  end

  assign sts.interior  = interior_r;
  assign sts.scan_last = (idx_r == hsvws_pkg::IDX_W'(hsvws_pkg::WIN_N - 1));
  assign sts.div_done  = (dcnt_r == hsvws_pkg::DCNT_W'(hsvws_pkg::SUM_W - 1));

endmodule

FILE: hw/rtl/hsv_window_similarity_average_top.sv
// Top level of the HSV window similarity average block: configuration
// registers and port, controller and datapath. Depends on hsvws_pkg,
// hsvws_ctrl and hsvws_datapath.
`timescale 1ns / 1ps

// Usage
// HSV pixels enter in raster order on the in_ stream, one item per pixel.
// For every pixel at row >= 4 and column >= 4 (a 5x5 window is complete) one
// result item leaves on the out_ stream for the window's centre pixel; border
// pixels give no result. A result carries the averaged HSV of the similar
// neighbors, or zero when the centre is rejected; out_tuser flags averaging
// and out_tlast marks the last interior pixel of the frame.
// Timing: a border pixel is only written to the line store. An interior pixel
// is written, its centre is read, its K*K = 25 window pixels are read through
// the single read port of the line store, and the bit-serial divider forms
// SUM_W = 13 quotient bits before out_tvalid rises. The next item is accepted
// in the cycle after the result is taken, so one item is handled at a time.
// When the receiver stalls, the result stays on out_ and no new item is taken.
// Synchronous reset returns the position to row 0, column 0 and loads the
// register defaults; the line store is not cleared and needs none.
// Registers are written over the APB-style port; the user must write them
// only while the block is idle, which the block itself does not enforce.

module hsv_window_similarity_average_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input pixel stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] hue, [15:8] sat, [23:16] val
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_hue, [15:8] out_sat, [23:16] out_val
  output logic        out_tuser,  // [0] averaged
  output logic        out_tlast,  // last interior pixel of the frame
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  hsvws_pkg::cfg_t     cfg_r;
  hsvws_pkg::reg_idx_t reg_idx;
  hsvws_pkg::cmd_t     cmd;
  hsvws_pkg::sts_t     sts;
  logic                wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = hsvws_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_window   <= 7'd10;
      cfg_r.sat_window   <= 8'd40;
      cfg_r.val_window   <= 8'd40;
      cfg_r.sat_floor    <= 8'd0;
      cfg_r.val_floor    <= 8'd0;
      cfg_r.good_factor  <= 7'd2;
      cfg_r.line_width   <= 11'd320;
      cfg_r.frame_height <= 12'd240;
    end else if (wr_en) begin
      case (reg_idx)
        hsvws_pkg::REG_HUE_WINDOW:   cfg_r.hue_window   <= cfg_pwdata[6:0];
        hsvws_pkg::REG_SAT_WINDOW:   cfg_r.sat_window   <= cfg_pwdata[7:0];
        hsvws_pkg::REG_VAL_WINDOW:   cfg_r.val_window   <= cfg_pwdata[7:0];
        hsvws_pkg::REG_SAT_FLOOR:    cfg_r.sat_floor    <= cfg_pwdata[7:0];
        hsvws_pkg::REG_VAL_FLOOR:    cfg_r.val_floor    <= cfg_pwdata[7:0];
        hsvws_pkg::REG_GOOD_FACTOR:  cfg_r.good_factor  <= cfg_pwdata[6:0];
        hsvws_pkg::REG_LINE_WIDTH:   cfg_r.line_width   <= cfg_pwdata[10:0];
        hsvws_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_pwdata[11:0];
        default:                     cfg_r              <= cfg_r;
      endcase
    end
  end

  // Read data is the addressed register, zero-extended.
  always_comb begin
    case (reg_idx)
      hsvws_pkg::REG_HUE_WINDOW:   cfg_prdata = 32'(cfg_r.hue_window);
      hsvws_pkg::REG_SAT_WINDOW:   cfg_prdata = 32'(cfg_r.sat_window);
      hsvws_pkg::REG_VAL_WINDOW:   cfg_prdata = 32'(cfg_r.val_window);
      hsvws_pkg::REG_SAT_FLOOR:    cfg_prdata = 32'(cfg_r.sat_floor);
      hsvws_pkg::REG_VAL_FLOOR:    cfg_prdata = 32'(cfg_r.val_floor);
      hsvws_pkg::REG_GOOD_FACTOR:  cfg_prdata = 32'(cfg_r.good_factor);
      hsvws_pkg::REG_LINE_WIDTH:   cfg_prdata = 32'(cfg_r.line_width);
      hsvws_pkg::REG_FRAME_HEIGHT: cfg_prdata = 32'(cfg_r.frame_height);
      default:                     cfg_prdata = '0;
    endcase
  end

  // The controller sequences one item at a time: store write and, for an interior
  // pixel, centre read, window scan, divide, then hold the result until the receiver takes it.
  hsvws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hsvws_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .pix_in   (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .res_data (out_tdata),
    .res_avg  (out_tuser),
    .res_last (out_tlast)
  );

endmodule

FILE: hw/rtl/hsvws_checker.sv
// Port-level checks for the HSV window similarity average block.
// Depends on nothing but the top level's ports; bound to the top level below.
`timescale 1ns / 1ps

module hsvws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // A pending result is held until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // No item is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is pending");

  // A rejected centre gives an all-zero pixel.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 24'd0)
    else $error("rejected result carries nonzero data");

  // An accepted item occupies the block for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("block not busy after accepting an item");

endmodule

bind hsv_window_similarity_average_top hsvws_checker u_hsvws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: bench/tb_hsv_window_similarity_average_top.sv
// Self-checking bench for hsv_window_similarity_average_top: raster pixel frames
// in, predicted window averages compared field by field. Depends on hsvws_pkg.
`timescale 1ns / 1ps

module tb_hsv_window_similarity_average_top;

  typedef struct packed {
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
    logic       avg;
    logic       last;
  } avg_result_t;

  // The smoothing predictor and its queue of expected averages.
  class smoothing_board;
    logic [7:0] store_h [hsvws_pkg::K][hsvws_pkg::MAX_WIDTH];
    logic [7:0] store_s [hsvws_pkg::K][hsvws_pkg::MAX_WIDTH];
    logic [7:0] store_v [hsvws_pkg::K][hsvws_pkg::MAX_WIDTH];
    int unsigned col, row;
    hsvws_pkg::cfg_t cfg;
    avg_result_t pending[$];
    int errors;

    function void reset_state();
      cfg.hue_window = 10; cfg.sat_window = 40; cfg.val_window = 40;
      cfg.sat_floor = 0; cfg.val_floor = 0; cfg.good_factor = 2;
      cfg.line_width = 320; cfg.frame_height = 240;
      col = 0; row = 0;
    endfunction

    function void write_reg(hsvws_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        hsvws_pkg::REG_HUE_WINDOW:   cfg.hue_window = value[6:0];
        hsvws_pkg::REG_SAT_WINDOW:   cfg.sat_window = value[7:0];
        hsvws_pkg::REG_VAL_WINDOW:   cfg.val_window = value[7:0];
        hsvws_pkg::REG_SAT_FLOOR:    cfg.sat_floor = value[7:0];
        hsvws_pkg::REG_VAL_FLOOR:    cfg.val_floor = value[7:0];
        hsvws_pkg::REG_GOOD_FACTOR:  cfg.good_factor = value[6:0];
        hsvws_pkg::REG_LINE_WIDTH:   cfg.line_width = value[10:0];
        hsvws_pkg::REG_FRAME_HEIGHT: cfg.frame_height = value[11:0];
        default: ;
      endcase
    endfunction

    function automatic int absd(int a, int b);
      return a > b ? a - b : b - a;
    endfunction

    function void note_pixel(logic [7:0] ph, logic [7:0] ps, logic [7:0] pv);
      int unsigned w, ht, cs, cc, rs, nc, good, hs, ss, vs;
      int hc, sc, vc, hn, sn, vn, d, cd, hw;
      avg_result_t r;
      w = cfg.line_width; ht = cfg.frame_height;
      if (w < hsvws_pkg::K) w = hsvws_pkg::K;
      if (w > hsvws_pkg::MAX_WIDTH) w = hsvws_pkg::MAX_WIDTH;
      if (ht < hsvws_pkg::K) ht = hsvws_pkg::K;
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= ht) row = 0;
      store_h[row % hsvws_pkg::K][col] = ph;
      store_s[row % hsvws_pkg::K][col] = ps;
      store_v[row % hsvws_pkg::K][col] = pv;
      if (row + 1 >= hsvws_pkg::K && col + 1 >= hsvws_pkg::K) begin
        cs = (row - hsvws_pkg::RAD) % hsvws_pkg::K; cc = col - hsvws_pkg::RAD;
        hc = store_h[cs][cc]; sc = store_s[cs][cc]; vc = store_v[cs][cc];
        hw = cfg.hue_window;
        r = '0;
        if (sc >= cfg.sat_floor && vc >= cfg.val_floor) begin
          hs = hc; ss = sc; vs = vc; good = 1;
          for (int dr = 0; dr < hsvws_pkg::K; dr++) begin
            rs = (row + 1 + dr) % hsvws_pkg::K;
            for (int dc = 0; dc < hsvws_pkg::K; dc++) begin
              nc = col + 1 + dc - hsvws_pkg::K;
              hn = store_h[rs][nc]; sn = store_s[rs][nc]; vn = store_v[rs][nc];
              d = absd(hc, hn);
              cd = (180 - d < d) ? 180 - d : d;
              if (absd(sc, sn) <= cfg.sat_window && absd(vc, vn) <= cfg.val_window
                  && cd <= hw) begin
                // Hues that wrap around red are pulled to the nearer end.
                if (hc <= hw && d > 90) hs += 0;
                else if (hc >= 180 - hw && d > 90) hs += 179;
                else hs += hn;
                ss += sn; vs += vn; good++;
              end
            end
          end
          if (cfg.good_factor * good >= hsvws_pkg::K * hsvws_pkg::K + 1) begin
            r.h = hs / good; r.s = ss / good; r.v = vs / good; r.avg = 1;
          end
        end
        r.last = (row == ht - 1 && col == w - 1);
        pending.push_back(r);
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= ht) row = 0;
      end
    endfunction

    function void check_result(avg_result_t got);
      avg_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.h !== exp_r.h) begin
        $error("out_hue expected %0d actual %0d", exp_r.h, got.h); errors++;
      end
      if (got.s !== exp_r.s) begin
        $error("out_sat expected %0d actual %0d", exp_r.s, got.s); errors++;
      end
      if (got.v !== exp_r.v) begin
        $error("out_val expected %0d actual %0d", exp_r.v, got.v); errors++;
      end
      if (got.avg !== exp_r.avg) begin
        $error("averaged expected %0d actual %0d", exp_r.avg, got.avg); errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last_in_frame expected %0d actual %0d", exp_r.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tuser, out_tlast;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic cfg_pready;

  smoothing_board board = new();
  int send_idle_pct, recv_idle_pct;
  int stall_cycles;
  // The limit covers the interior pixel latency several times over plus the long
  // receiver stalls of the first idling phase.
  localparam int STALL_LIMIT = 20000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hsv_window_similarity_average_top dut (.*);

  // The receiver samples results at the edge and decides its ready for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result('{out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
                           out_tuser, out_tlast});
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: counts cycles in which no item moves on either stream.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_hsv_window_similarity_average_top: FAIL");
      $finish;
    end
  end

  task automatic write_reg(hsvws_pkg::reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= 5'(idx) << 2; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    board.write_reg(idx, value);
  endtask

  // tvalid stays high from one item to the next unless the sender idles.
  task automatic send_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {v, s, h};
    do @(posedge clk); while (!in_tready);
    board.note_pixel(h, s, v);
  endtask

  // Waits for every expected result, then lets a border pixel's work settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // A whole frame with mostly similar pixels clustered near one colour; noise
  // pixels are mixed in so that both outcomes of the ratio test appear.
  task automatic send_frame(int w, int ht, int noise_pct);
    logic [7:0] h0, s0, v0;
    h0 = $urandom_range(179); s0 = $urandom; v0 = $urandom;
    for (int i = 0; i < w * ht; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_pixel($urandom, $urandom, $urandom);
      else
        send_pixel(8'((h0 + $urandom_range(24) + 168) % 180),
                   8'(s0 + $urandom_range(40) - 20), 8'(v0 + $urandom_range(40) - 20));
    end
  endtask

  task automatic set_geometry(int w, int ht);
    write_reg(hsvws_pkg::REG_LINE_WIDTH, w);
    write_reg(hsvws_pkg::REG_FRAME_HEIGHT, ht);
  endtask

  initial begin
    board.reset_state();
    send_idle_pct = 32; recv_idle_pct = 87;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: one 5x5 frame holding field extremes and the red wrap.
    set_geometry(5, 5);
    write_reg(hsvws_pkg::REG_HUE_WINDOW, 90);
    write_reg(hsvws_pkg::REG_GOOD_FACTOR, 1);
    for (int i = 0; i < 25; i++) begin
      case (i % 5)
        0: send_pixel(8'd0, 8'd255, 8'd255);
        1: send_pixel(8'd179, 8'd250, 8'd250);
        2: send_pixel(8'd255, 8'd0, 8'd0);
        3: send_pixel(8'd2, 8'd245, 8'd240);
        default: send_pixel(8'd177, 8'd255, 8'd255);
      endcase
    end
    drain();

    // Zero factor never averages; widths below the kernel saturate to five.
    write_reg(hsvws_pkg::REG_GOOD_FACTOR, 0);
    write_reg(hsvws_pkg::REG_LINE_WIDTH, 2);
    write_reg(hsvws_pkg::REG_FRAME_HEIGHT, 0);
    send_frame(5, 5, 50);
    drain();

    // Random phases through several register settings and idling patterns.
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 87; recv_idle_pct = 32;
      end else if (phase == 6) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      write_reg(hsvws_pkg::REG_HUE_WINDOW, (phase == 0) ? 0 : $urandom_range(90));
      write_reg(hsvws_pkg::REG_SAT_WINDOW, (phase == 1) ? 255 : $urandom_range(80));
      write_reg(hsvws_pkg::REG_VAL_WINDOW, (phase == 1) ? 0 : $urandom_range(80));
      write_reg(hsvws_pkg::REG_SAT_FLOOR, (phase == 2) ? 255 : $urandom_range(60));
      write_reg(hsvws_pkg::REG_VAL_FLOOR, (phase == 4) ? 255 : $urandom_range(60));
      write_reg(hsvws_pkg::REG_GOOD_FACTOR, (phase == 5) ? 82 : $urandom_range(1, 4));
      if (phase == 7) begin
        // Part of one row at full width; the narrower width of the next phase
        // leaves the column past the end, so the position wraps to a new row.
        set_geometry(1024, 5);
        send_frame(300, 1, 20);
      end else begin
        set_geometry($urandom_range(5, 9), $urandom_range(5, 8));
        send_frame(board.cfg.line_width, board.cfg.frame_height, 15);
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_hsv_window_similarity_average_top: PASS");
    else
      $display("tb_hsv_window_similarity_average_top: FAIL");
    $finish;
  end
endmodule
